// File: hdl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants for the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int GLYPH_WIDTH          = 8;
    localparam int GLYPH_HEIGHT_DEFAULT = 16;
    localparam int GLYPH_COUNT_DEFAULT  = 256;

    localparam int X_SHIFT     = $clog2(GLYPH_WIDTH);
    localparam int COORD_W     = 11;
    localparam int CODE_IN_W   = 8;
    localparam int GROW_IN_W   = 4;
    localparam int COL_W       = 8;
    localparam int CROW_W      = 8;
    localparam int ROWS_CFG_W  = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CODE_IN_W-1:0]  NEWLINE_CODE  = 8'd10;
    localparam logic [COL_W-1:0]      COLUMNS_RESET = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET    = 7'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FG_COLOUR = 2'd0,
        REG_BG_COLOUR = 2'd1,
        REG_COLUMNS   = 2'd2,
        REG_ROWS      = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_PUT  = 1'b0,
        ACT_LOAD = 1'b1
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DRAW = 1'b1
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic [GLYPH_WIDTH-1:0] bits;
        logic                   last;
    } result_t;

endpackage

// File: hdl/tcgr_ram.sv
// ----------------------------------------------------------------------------
// tcgr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/text_console_glyph_renderer_top.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console character generator: font row loads and glyph row output.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+-----------------------
//  item    | item_valid/ready, action, char_code,      | in  | font load or character
//          | glyph_row, font_bits                      |     |
//  result  | result_valid/ready, pixel_x, pixel_y,     | out | one per glyph row
//          | row_pixels, last_row                      |     |
//  cfg     | cfg_valid/ready, cfg_index, cfg_data      | in  | always ready
//
//  Font loads and newlines complete on acceptance. A character is accepted and
//  its cursor wrapped first, then one font row is read per cycle
//  from the single RAM read port. Results queue in a two-entry output buffer;
//  a stalled result port holds back the row reads. No clearing pass after
//  reset: font entries read before being written are undefined.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top #(
    parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEFAULT,
    parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                action,
    input  logic [tcgr_pkg::CODE_IN_W-1:0]      char_code,
    input  logic [tcgr_pkg::GROW_IN_W-1:0]      glyph_row,
    input  logic [tcgr_pkg::GLYPH_WIDTH-1:0]    font_bits,

    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [tcgr_pkg::COORD_W-1:0]        pixel_x,
    output logic [tcgr_pkg::COORD_W-1:0]        pixel_y,
    output logic [tcgr_pkg::GLYPH_WIDTH-1:0]    row_pixels,
    output logic                                last_row,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import tcgr_pkg::*;

    localparam int ROW_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam int CODE_W = $clog2(GLYPH_COUNT);
    localparam int ADDR_W = CODE_W + ROW_W;
    localparam int DEPTH  = GLYPH_COUNT * (2 ** ROW_W);
    localparam int YP_W   = CROW_W + 5;

    localparam logic [ROW_W-1:0] LAST_ROW_IDX = ROW_W'(GLYPH_HEIGHT - 1);

    state_t                  state_reg, state_next;
    logic [COL_W-1:0]        cursor_col_reg, cursor_col_next;
    logic [CROW_W-1:0]       cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]        columns_reg;
    logic [ROWS_CFG_W-1:0]   rows_reg;

    logic [CODE_W-1:0]       code_reg;
    logic                    blank_reg;
    logic [COORD_W-1:0]      draw_x_reg;
    logic [COORD_W-1:0]      base_y_reg;
    logic [ROW_W-1:0]        rd_row_reg;

    logic                    inflight_reg;
    result_t                 meta_reg;
    logic                    meta_blank_reg;

    result_t                 fifo_mem [2];
    logic                    wr_ptr_reg, rd_ptr_reg;
    logic [1:0]              count_reg, count_next;

    logic                    item_fire, cfg_fire;
    logic                    is_load, is_newline, is_put;
    logic                    load_ok, code_ok;
    logic                    col_full, row_wrap;
    logic [CROW_W-1:0]       row_step, row_w;
    logic [COL_W-1:0]        col_w;
    logic [YP_W-1:0]         y_prod;
    logic                    pop, push, issue, last_issue;
    logic [1:0]              occ;
    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr, ram_rd_addr;
    logic [GLYPH_WIDTH-1:0]  ram_rd_data;
    result_t                 head;

    // ---------------------------------------------------------------- decode
    assign item_fire  = item_valid && item_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;

    assign is_load    = (action_t'(action) == ACT_LOAD);
    assign is_newline = !is_load && (char_code == NEWLINE_CODE);
    assign is_put     = !is_load && !is_newline;

    assign code_ok    = ({1'b0, char_code} < 9'(GLYPH_COUNT));
    assign load_ok    = code_ok && ({1'b0, glyph_row} < 5'(GLYPH_HEIGHT));

    // cursor wrap ahead of drawing; zero geometry always wraps
    assign col_full   = (cursor_col_reg >= columns_reg);
    assign row_step   = col_full ? (cursor_row_reg + 8'd1) : cursor_row_reg;
    assign row_wrap   = (row_step >= {1'b0, rows_reg});
    assign row_w      = row_wrap ? '0 : row_step;
    assign col_w      = col_full ? '0 : cursor_col_reg;
    assign y_prod     = YP_W'(row_w) * YP_W'(GLYPH_HEIGHT);

    // -------------------------------------------------------- row read issue
    assign pop        = result_valid && result_ready;
    assign push       = inflight_reg;
    assign occ        = count_reg + {1'b0, inflight_reg};
    // a read is issued only if the output buffer has room when its data lands
    assign issue      = (state_reg == ST_DRAW) && ((occ < 2'd2) || pop);
    assign last_issue = issue && (rd_row_reg == LAST_ROW_IDX);

    // ------------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && is_put)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (last_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // writes only happen in idle and reads only in draw, so the two never meet
    always_comb
    begin
        case (state_reg)
            ST_IDLE: item_ready = 1'b1;
            ST_DRAW: item_ready = 1'b0;
            default: item_ready = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- cursor
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (item_fire && is_newline)
        begin
            cursor_col_next = '0;
            cursor_row_next = cursor_row_reg + 8'd1;
        end
        else if (item_fire && is_put)
        begin
            cursor_col_next = col_w + 8'd1;
            cursor_row_next = row_w;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            columns_reg    <= COLUMNS_RESET;
            rows_reg       <= ROWS_RESET;
            rd_row_reg     <= '0;
            inflight_reg   <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            inflight_reg   <= issue;
            count_reg      <= count_next;
            if (issue)
            begin
                rd_row_reg <= last_issue ? '0 : (rd_row_reg + ROW_W'(1));
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (cfg_fire)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_COLUMNS: columns_reg <= cfg_data[COL_W-1:0];
                    REG_ROWS:    rows_reg    <= cfg_data[ROWS_CFG_W-1:0];
                    // colours take no part in the emitted bits
                    REG_FG_COLOUR, REG_BG_COLOUR:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // --------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (item_fire && is_put)
        begin
            code_reg   <= char_code[CODE_W-1:0];
            blank_reg  <= !code_ok;
            draw_x_reg <= COORD_W'(col_w) << X_SHIFT;
            base_y_reg <= y_prod[COORD_W-1:0];
        end
        if (issue)
        begin
            meta_reg.x     <= draw_x_reg;
            meta_reg.y     <= base_y_reg + COORD_W'(rd_row_reg);
            meta_reg.bits  <= '0;
            meta_reg.last  <= (rd_row_reg == LAST_ROW_IDX);
            meta_blank_reg <= blank_reg;
        end
        if (push)
        begin
            fifo_mem[wr_ptr_reg].x    <= meta_reg.x;
            fifo_mem[wr_ptr_reg].y    <= meta_reg.y;
            fifo_mem[wr_ptr_reg].bits <= meta_blank_reg ? '0 : ram_rd_data;
            fifo_mem[wr_ptr_reg].last <= meta_reg.last;
        end
    end

    // ------------------------------------------------------------- font RAM
    assign ram_wr_en   = item_fire && is_load && load_ok;
    assign ram_wr_addr = {char_code[CODE_W-1:0], glyph_row[ROW_W-1:0]};
    assign ram_rd_addr = {code_reg, rd_row_reg};

    tcgr_ram #(
        .WIDTH (GLYPH_WIDTH),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_font_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(font_bits),
        .rd_en  (issue),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // ---------------------------------------------------------------- output
    assign head         = fifo_mem[rd_ptr_reg];
    assign result_valid = (count_reg != 2'd0);
    assign pixel_x      = head.x;
    assign pixel_y      = head.y;
    assign row_pixels   = head.bits;
    assign last_row     = head.last;

endmodule

// File: hdl/tcgr_checker.sv
// ----------------------------------------------------------------------------
// tcgr_checker
// Port-level checks for the glyph renderer, bound to the top level.
// ----------------------------------------------------------------------------
module tcgr_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic [tcgr_pkg::COORD_W-1:0]     pixel_x,
    input  logic [tcgr_pkg::COORD_W-1:0]     pixel_y,
    input  logic [tcgr_pkg::GLYPH_WIDTH-1:0] row_pixels,
    input  logic                             last_row,
    input  logic                             cfg_ready
);

    import tcgr_pkg::*;

    // stalled result keeps its transaction intact
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(pixel_x)
            && $stable(pixel_y) && $stable(row_pixels) && $stable(last_row))
        else $error("result changed while stalled");

    // x is always a whole glyph cell
    a_x_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pixel_x[X_SHIFT-1:0] == '0))
        else $error("pixel_x not cell aligned");

    // back-to-back rows of one glyph: same x, next y
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !last_row) ##1 (result_valid && result_ready)
            |-> (pixel_x == $past(pixel_x)) && (pixel_y == $past(pixel_y) + 11'd1))
        else $error("glyph rows out of step");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind text_console_glyph_renderer_top tcgr_checker u_tcgr_checker (.*);
